// ----- hw/rtl/mcf_pkg.sv -----
// shared types and constants of the max-cost flow solver
`default_nettype none
package mcf_pkg;

  localparam int NODE_W  = 9;
  localparam int CAP_W   = 30;
  localparam int COST_W  = 21;
  localparam int GAIN_W  = 22;
  localparam int TOTAL_W = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 1'b1;

  localparam logic [CAP_W-1:0] SOURCE_LIMIT = 30'd1000000000;
  localparam logic [CAP_W-1:0] CAP_MAX      = 30'h3fffffff;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_LINK_FWD,
    OP_HEAD_RD,
    OP_LINK_REV,
    OP_INIT,
    OP_SEED,
    OP_POP,
    OP_UREAD,
    OP_ULOAD,
    OP_ECHK,
    OP_ERD,
    OP_EREL,
    OP_FIN,
    OP_FINCHK,
    OP_AUGCHK,
    OP_AUGPRED,
    OP_AUGSUB,
    OP_AUGADD,
    OP_MULLO,
    OP_MULHI,
    OP_MACC,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic last_edge;
    logic term_bad;
    logic q_empty;
    logic i_end;
    logic res_zero;
    logic cycle;
    logic dst_reached;
    logic aug_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mcf_dp.sv -----
// datapath: edge store, node state, work queue, arithmetic and output register
`default_nettype none
module mcf_dp #(
  parameter int MAX_NODES = 512,
  parameter int MAX_EDGES = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire mcf_pkg::cmd_t                        cmd,
  output mcf_pkg::status_t                          status,
  input  wire logic [mcf_pkg::NODE_W-1:0]           in_from_node,
  input  wire logic [mcf_pkg::NODE_W-1:0]           in_to_node,
  input  wire logic [mcf_pkg::CAP_W-1:0]            in_capacity,
  input  wire logic signed [mcf_pkg::COST_W-1:0]    in_cost,
  input  wire logic                                 in_last_edge,
  input  wire logic                                 cfg_we,
  input  wire logic [mcf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [mcf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [mcf_pkg::TOTAL_W-1:0]        out_total_cost
);

  localparam int NW     = $clog2(MAX_NODES);
  localparam int ESLOTS = 2 * MAX_EDGES + 2;
  localparam int EW     = $clog2(ESLOTS);
  localparam int GW     = mcf_pkg::GAIN_W;
  localparam int CW     = mcf_pkg::CAP_W;
  localparam int RW     = 1 + 64 + EW + CW + NW;
  localparam int EDW    = NW + GW + EW;

  function automatic logic [NW-1:0] wrap_inc(input logic [NW-1:0] x);
    logic [NW-1:0] y;
    y = x + NW'(1);
    if (32'(x) == MAX_NODES - 1) y = '0;
    return y;
  endfunction

  // memories
  logic [EW-1:0]  head_mem  [MAX_NODES];
  logic [EDW-1:0] edge_mem  [ESLOTS];
  logic [CW-1:0]  res_mem   [ESLOTS];
  logic [RW-1:0]  rec_mem   [MAX_NODES];
  logic           qd_mem    [MAX_NODES];
  logic [NW-1:0]  queue_mem [MAX_NODES];

  logic [EW-1:0]  head_rd_r;
  logic [EDW-1:0] edge_rd_r;
  logic [CW-1:0]  res_rd_r;
  logic [RW-1:0]  rec_rd_r;
  logic           qd_rd_r;
  logic [NW-1:0]  queue_rd_r;

  logic           head_we, edge_we, res_we, rec_we, qd_we, queue_we;
  logic [NW-1:0]  head_wa, head_ra, rec_wa, rec_ra, qd_wa, qd_ra, queue_wa;
  logic [EW-1:0]  head_wd, edge_wa, res_wa, e_ra;
  logic [EDW-1:0] edge_wd;
  logic [CW-1:0]  res_wd;
  logic [RW-1:0]  rec_wd;
  logic           qd_wd;
  logic [NW-1:0]  queue_wd;

  // registers
  logic [mcf_pkg::NODE_W-1:0] src_r, dst_r;
  logic [NW-1:0]  from_r, to_r, cnt_r, qh_r, qt_r, u_r, v_r, hu_r;
  logic [NW:0]    qn_r, steps_r;
  logic [CW-1:0]  cap_r, bu_r, eres_r, f_r;
  logic [GW-1:0]  in_gain_r, egain_r;
  logic           last_r, ok_r;
  logic [EW-1:0]  ec_r, i_r, elink_r;
  logic [63:0]    cost_r, du_r, dd_r;
  logic [61:0]    prod_r;
  logic           out_valid_r;
  logic [63:0]    out_total_r;

  // decoded reads
  logic [NW-1:0]  ed_target;
  logic [GW-1:0]  ed_gain;
  logic [EW-1:0]  ed_link;
  logic           rv_reached;
  logic [63:0]    rv_dist;
  logic [EW-1:0]  rv_pred;
  logic [CW-1:0]  rv_bott;
  logic [NW-1:0]  rv_hops;

  logic [EW-1:0]  k1, k2;
  logic [63:0]    cand;
  logic           no_gain, cyc, do_upd, push;
  logic [NW-1:0]  hops_new;
  logic [CW-1:0]  bnew;
  logic [CW:0]    sat_sum;
  logic [CW-1:0]  sat_res;
  logic [31:0]    mul_b;
  logic [61:0]    mul_p;
  logic           accept_ok;
  logic           out_free;

  assign ed_target = edge_rd_r[EDW-1 -: NW];
  assign ed_gain   = edge_rd_r[EW+GW-1 -: GW];
  assign ed_link   = edge_rd_r[EW-1:0];
  assign rv_reached = rec_rd_r[RW-1];
  assign rv_dist    = rec_rd_r[RW-2 -: 64];
  assign rv_pred    = rec_rd_r[RW-66 -: EW];
  assign rv_bott    = rec_rd_r[NW+CW-1 -: CW];
  assign rv_hops    = rec_rd_r[NW-1:0];

  assign k1 = ec_r + EW'(1);
  assign k2 = ec_r + EW'(2);

  assign cand     = du_r + {{(64-GW){egain_r[GW-1]}}, egain_r};
  assign no_gain  = rv_reached && ($signed(cand) <= $signed(rv_dist));
  assign cyc      = !no_gain && (32'(hu_r) + 32'd1 >= MAX_NODES);
  assign do_upd   = !no_gain && !cyc;
  assign push     = do_upd && !qd_rd_r && (32'(qn_r) < MAX_NODES);
  assign hops_new = hu_r + NW'(1);
  assign bnew     = (bu_r < eres_r) ? bu_r : eres_r;

  assign sat_sum = {1'b0, res_rd_r} + {1'b0, f_r};
  assign sat_res = sat_sum[CW] ? mcf_pkg::CAP_MAX : sat_sum[CW-1:0];

  assign mul_b = (cmd.op == mcf_pkg::OP_MULHI) ? dd_r[63:32] : dd_r[31:0];
  assign mul_p = 62'(f_r) * 62'(mul_b);

  assign accept_ok = (32'(in_from_node) < MAX_NODES) && (32'(in_to_node) < MAX_NODES) &&
                     (32'(ec_r) + 32'd2 <= ESLOTS - 1);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    status.cnt_last    = (32'(cnt_r) == MAX_NODES - 1);
    status.last_edge   = last_r;
    status.term_bad    = (32'(src_r) >= MAX_NODES) || (32'(dst_r) >= MAX_NODES) ||
                         (src_r == dst_r);
    status.q_empty     = (qn_r == '0);
    status.i_end       = (i_r == '0) || (32'(i_r) >= ESLOTS);
    status.res_zero    = (res_rd_r == '0);
    status.cycle       = cyc;
    status.dst_reached = rv_reached;
    status.aug_done    = (v_r == NW'(src_r)) || (32'(steps_r) >= MAX_NODES);
    status.out_free    = out_free;
  end

  // memory port steering
  always_comb begin
    head_we  = 1'b0;
    head_wa  = cnt_r;
    head_wd  = '0;
    head_ra  = NW'(in_from_node);
    edge_we  = 1'b0;
    edge_wa  = k1;
    edge_wd  = '0;
    res_we   = 1'b0;
    res_wa   = i_r;
    res_wd   = '0;
    e_ra     = i_r;
    rec_we   = 1'b0;
    rec_wa   = cnt_r;
    rec_wd   = '0;
    rec_ra   = v_r;
    qd_we    = 1'b0;
    qd_wa    = cnt_r;
    qd_wd    = 1'b0;
    qd_ra    = ed_target;
    queue_we = 1'b0;
    queue_wa = qt_r;
    queue_wd = v_r;
    unique case (cmd.op)
      mcf_pkg::OP_CLEAR: begin
        head_we = 1'b1;
      end
      mcf_pkg::OP_LINK_FWD: begin
        head_we = ok_r;
        head_wa = from_r;
        head_wd = k1;
        edge_we = ok_r;
        edge_wd = {to_r, in_gain_r, head_rd_r};
        res_we  = ok_r;
        res_wa  = k1;
        res_wd  = cap_r;
      end
      mcf_pkg::OP_HEAD_RD: begin
        head_ra = to_r;
      end
      mcf_pkg::OP_LINK_REV: begin
        head_we = ok_r;
        head_wa = to_r;
        head_wd = k2;
        edge_we = ok_r;
        edge_wa = k2;
        edge_wd = {from_r, -in_gain_r, head_rd_r};
        res_we  = ok_r;
        res_wa  = k2;
        res_wd  = '0;
      end
      mcf_pkg::OP_INIT: begin
        rec_we = 1'b1;
        qd_we  = 1'b1;
      end
      mcf_pkg::OP_SEED: begin
        rec_we   = 1'b1;
        rec_wa   = NW'(src_r);
        rec_wd   = {1'b1, 64'd0, {EW{1'b0}}, mcf_pkg::SOURCE_LIMIT, {NW{1'b0}}};
        qd_we    = 1'b1;
        qd_wa    = NW'(src_r);
        qd_wd    = 1'b1;
        queue_we = 1'b1;
        queue_wa = '0;
        queue_wd = NW'(src_r);
      end
      mcf_pkg::OP_UREAD: begin
        head_ra = queue_rd_r;
        rec_ra  = queue_rd_r;
        qd_we   = 1'b1;
        qd_wa   = queue_rd_r;
      end
      mcf_pkg::OP_ERD: begin
        rec_ra = ed_target;
      end
      mcf_pkg::OP_EREL: begin
        rec_we   = do_upd;
        rec_wa   = v_r;
        rec_wd   = {1'b1, cand, i_r, bnew, hops_new};
        qd_we    = push;
        qd_wa    = v_r;
        qd_wd    = 1'b1;
        queue_we = push;
      end
      mcf_pkg::OP_FIN: begin
        rec_ra = NW'(dst_r);
      end
      mcf_pkg::OP_AUGPRED: begin
        e_ra = rv_pred;
      end
      mcf_pkg::OP_AUGSUB: begin
        res_we = 1'b1;
        res_wd = res_rd_r - f_r;
        e_ra   = i_r ^ EW'(1);
      end
      mcf_pkg::OP_AUGADD: begin
        res_we = 1'b1;
        res_wa = i_r ^ EW'(1);
        res_wd = sat_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    edge_rd_r <= edge_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    res_rd_r <= res_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_rd_r <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk) begin
    if (qd_we) qd_mem[qd_wa] <= qd_wd;
    qd_rd_r <= qd_mem[qd_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_rd_r <= queue_mem[qh_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r       <= '0;
      dst_r       <= mcf_pkg::CFG_DATA_W'(1);
      cnt_r       <= '0;
      ec_r        <= EW'(1);
      cost_r      <= '0;
      qh_r        <= '0;
      qt_r        <= '0;
      qn_r        <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == mcf_pkg::CFG_SOURCE) src_r <= cfg_wdata;
        if (cfg_index == mcf_pkg::CFG_SINK)   dst_r <= cfg_wdata;
      end
      if (cmd.op == mcf_pkg::OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        mcf_pkg::OP_CLEAR: begin
          cnt_r  <= wrap_inc(cnt_r);
          ec_r   <= EW'(1);
          cost_r <= '0;
        end
        mcf_pkg::OP_ACCEPT: begin
          last_r <= in_last_edge;
        end
        mcf_pkg::OP_LINK_REV: begin
          if (ok_r) ec_r <= k2;
        end
        mcf_pkg::OP_INIT: begin
          cnt_r <= wrap_inc(cnt_r);
        end
        mcf_pkg::OP_SEED: begin
          qh_r <= '0;
          qt_r <= wrap_inc('0);
          qn_r <= (NW+1)'(1);
        end
        mcf_pkg::OP_UREAD: begin
          qh_r <= wrap_inc(qh_r);
          qn_r <= qn_r - (NW+1)'(1);
        end
        mcf_pkg::OP_EREL: begin
          if (push) begin
            qt_r <= wrap_inc(qt_r);
            qn_r <= qn_r + (NW+1)'(1);
          end
        end
        mcf_pkg::OP_MULHI: begin
          cost_r <= cost_r + 64'(prod_r);
        end
        mcf_pkg::OP_MACC: begin
          cost_r <= cost_r + {prod_r[31:0], 32'd0};
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mcf_pkg::OP_ACCEPT: begin
        from_r    <= NW'(in_from_node);
        to_r      <= NW'(in_to_node);
        cap_r     <= in_capacity;
        in_gain_r <= {in_cost[mcf_pkg::COST_W-1], in_cost};
        ok_r      <= accept_ok;
      end
      mcf_pkg::OP_UREAD: begin
        u_r <= queue_rd_r;
      end
      mcf_pkg::OP_ULOAD: begin
        du_r <= rv_dist;
        bu_r <= rv_bott;
        hu_r <= rv_hops;
        i_r  <= head_rd_r;
      end
      mcf_pkg::OP_ERD: begin
        v_r     <= ed_target;
        egain_r <= ed_gain;
        elink_r <= ed_link;
        eres_r  <= res_rd_r;
        if (res_rd_r == '0) i_r <= ed_link;
      end
      mcf_pkg::OP_EREL: begin
        i_r <= elink_r;
        if (do_upd && v_r == u_r) begin
          du_r <= cand;
          bu_r <= bnew;
          hu_r <= hops_new;
        end
      end
      mcf_pkg::OP_FINCHK: begin
        f_r     <= rv_bott;
        dd_r    <= rv_dist;
        v_r     <= NW'(dst_r);
        steps_r <= '0;
      end
      mcf_pkg::OP_AUGPRED: begin
        i_r <= rv_pred;
      end
      mcf_pkg::OP_AUGADD: begin
        v_r     <= ed_target;
        steps_r <= steps_r + (NW+1)'(1);
      end
      mcf_pkg::OP_MULLO, mcf_pkg::OP_MULHI: begin
        prod_r <= mul_p;
      end
      mcf_pkg::OP_EMIT: begin
        if (out_free) out_total_r <= cost_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_total_cost = $signed(out_total_r);

endmodule
`default_nettype wire

// ----- hw/rtl/mcf_ctrl.sv -----
// controller state machine sequencing load, search, augment and result
`default_nettype none
module mcf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire mcf_pkg::status_t status,
  output mcf_pkg::cmd_t         cmd
);

  typedef enum logic [23:0] {
    ST_CLEAR = 24'h000001,
    ST_IDLE  = 24'h000002,
    ST_LD1   = 24'h000004,
    ST_LD2   = 24'h000008,
    ST_LD3   = 24'h000010,
    ST_START = 24'h000020,
    ST_INIT  = 24'h000040,
    ST_SEED  = 24'h000080,
    ST_POP   = 24'h000100,
    ST_UREAD = 24'h000200,
    ST_ULOAD = 24'h000400,
    ST_ECHK  = 24'h000800,
    ST_ERD   = 24'h001000,
    ST_EREL  = 24'h002000,
    ST_FIN   = 24'h004000,
    ST_FIN2  = 24'h008000,
    ST_AUG   = 24'h010000,
    ST_AUG1  = 24'h020000,
    ST_AUG2  = 24'h040000,
    ST_AUG3  = 24'h080000,
    ST_MUL1  = 24'h100000,
    ST_MUL2  = 24'h200000,
    ST_MACC  = 24'h400000,
    ST_EMIT  = 24'h800000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = mcf_pkg::OP_NONE;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.op = mcf_pkg::OP_CLEAR;
        if (status.cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = mcf_pkg::OP_ACCEPT;
          state_nxt = ST_LD1;
        end
      end
      ST_LD1: begin
        cmd.op    = mcf_pkg::OP_LINK_FWD;
        state_nxt = ST_LD2;
      end
      ST_LD2: begin
        cmd.op    = mcf_pkg::OP_HEAD_RD;
        state_nxt = ST_LD3;
      end
      ST_LD3: begin
        cmd.op    = mcf_pkg::OP_LINK_REV;
        state_nxt = status.last_edge ? ST_START : ST_IDLE;
      end
      ST_START: begin
        state_nxt = status.term_bad ? ST_EMIT : ST_INIT;
      end
      ST_INIT: begin
        cmd.op = mcf_pkg::OP_INIT;
        if (status.cnt_last) state_nxt = ST_SEED;
      end
      ST_SEED: begin
        cmd.op    = mcf_pkg::OP_SEED;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        cmd.op    = mcf_pkg::OP_POP;
        state_nxt = status.q_empty ? ST_FIN : ST_UREAD;
      end
      ST_UREAD: begin
        cmd.op    = mcf_pkg::OP_UREAD;
        state_nxt = ST_ULOAD;
      end
      ST_ULOAD: begin
        cmd.op    = mcf_pkg::OP_ULOAD;
        state_nxt = ST_ECHK;
      end
      ST_ECHK: begin
        cmd.op    = mcf_pkg::OP_ECHK;
        state_nxt = status.i_end ? ST_POP : ST_ERD;
      end
      ST_ERD: begin
        cmd.op    = mcf_pkg::OP_ERD;
        state_nxt = status.res_zero ? ST_ECHK : ST_EREL;
      end
      ST_EREL: begin
        cmd.op    = mcf_pkg::OP_EREL;
        state_nxt = status.cycle ? ST_EMIT : ST_ECHK;
      end
      ST_FIN: begin
        cmd.op    = mcf_pkg::OP_FIN;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.op    = mcf_pkg::OP_FINCHK;
        state_nxt = status.dst_reached ? ST_AUG : ST_EMIT;
      end
      ST_AUG: begin
        cmd.op    = mcf_pkg::OP_AUGCHK;
        state_nxt = status.aug_done ? ST_MUL1 : ST_AUG1;
      end
      ST_AUG1: begin
        cmd.op    = mcf_pkg::OP_AUGPRED;
        state_nxt = ST_AUG2;
      end
      ST_AUG2: begin
        cmd.op    = mcf_pkg::OP_AUGSUB;
        state_nxt = ST_AUG3;
      end
      ST_AUG3: begin
        cmd.op    = mcf_pkg::OP_AUGADD;
        state_nxt = ST_AUG;
      end
      ST_MUL1: begin
        cmd.op    = mcf_pkg::OP_MULLO;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op    = mcf_pkg::OP_MULHI;
        state_nxt = ST_MACC;
      end
      ST_MACC: begin
        cmd.op    = mcf_pkg::OP_MACC;
        state_nxt = ST_INIT;
      end
      ST_EMIT: begin
        cmd.op = mcf_pkg::OP_EMIT;
        if (status.out_free) state_nxt = ST_CLEAR;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/max_cost_flow_spfa_top.sv -----
// top level of the max-cost max-flow solver
// Input channel: one directed edge per item (from, to, capacity, cost, last_edge),
// taken when in_valid is high and in_stall low. Each edge is linked with its
// zero-capacity reverse edge into per-node adjacency lists; an item is loaded by
// head-list read, forward link, head read and reverse link, in that order.
// The item with last_edge set starts the solve: repeated longest-path searches
// (queue-based relaxation: pop, node read, node load per node; check, read and
// relax per edge; a sweep of all MAX_NODES node states opens each search), each
// followed by an augment walk (check, pred read, subtract, add per path edge) and
// multiply-accumulate. The total appears as one item on out_valid/out_total_cost.
// The output register holds the result while out_stall is high; the solver waits
// there only if an earlier result has not yet been taken.
// After reset and after every result, a clearing pass over all MAX_NODES nodes
// empties the adjacency heads; in_stall stays high during it. Configuration writes
// (source_node index 0, sink_node index 1) are taken at any time.
`default_nettype none
module max_cost_flow_spfa_top #(
  parameter int MAX_NODES = 512,
  parameter int MAX_EDGES = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [mcf_pkg::NODE_W-1:0]        in_from_node,
  input  wire logic [mcf_pkg::NODE_W-1:0]        in_to_node,
  input  wire logic [mcf_pkg::CAP_W-1:0]         in_capacity,
  input  wire logic signed [mcf_pkg::COST_W-1:0] in_cost,
  input  wire logic                              in_last_edge,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [mcf_pkg::TOTAL_W-1:0]     out_total_cost,
  input  wire logic                              cfg_we,
  input  wire logic [mcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mcf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  mcf_pkg::cmd_t    cmd;
  mcf_pkg::status_t status;

  mcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mcf_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_from_node   (in_from_node),
    .in_to_node     (in_to_node),
    .in_capacity    (in_capacity),
    .in_cost        (in_cost),
    .in_last_edge   (in_last_edge),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_total_cost (out_total_cost)
  );

  a_no_result_mid_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_last_edge) |=> !$rose(out_valid))
    else $error("result raised by a non-final edge");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_stall)
    else $error("result raised while input side open");

  a_accept_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == mcf_pkg::OP_ACCEPT) |-> (in_valid && !in_stall))
    else $error("edge captured without handshake");

endmodule
`default_nettype wire

// ----- bench/tb_max_cost_flow_spfa_top.sv -----
// testbench for the max-cost max-flow solver: edge sets checked against a flow predictor
`default_nettype none
module tb_max_cost_flow_spfa_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 512;
  localparam int SLOTS = 2 * 4096 + 2;
  localparam int unsigned LIMIT = 1000000000;

  typedef enum bit [1:0] {K_EDGE, K_CFG, K_DRAIN} step_kind_t;
  typedef struct {
    step_kind_t kind;
    logic [mcf_pkg::NODE_W-1:0] from_n;
    logic [mcf_pkg::NODE_W-1:0] to_n;
    logic [mcf_pkg::CAP_W-1:0] cap;
    logic signed [mcf_pkg::COST_W-1:0] cost;
    logic last;
    logic [mcf_pkg::CFG_IDX_W-1:0] idx;
    logic [mcf_pkg::CFG_DATA_W-1:0] data;
  } step_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, in_last_edge = 0;
  logic [mcf_pkg::NODE_W-1:0] in_from_node = '0, in_to_node = '0;
  logic [mcf_pkg::CAP_W-1:0] in_capacity = '0;
  logic signed [mcf_pkg::COST_W-1:0] in_cost = '0;
  logic out_valid, out_stall = 0;
  logic signed [mcf_pkg::TOTAL_W-1:0] out_total_cost;
  logic cfg_we = 0;
  logic [mcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mcf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  max_cost_flow_spfa_top i_dut (.*);

  step_t pending[$];
  longint expected_totals[$];
  bit in_took = 0;
  int accepted = 0, cycles = 0, settle = 0, mismatches = 0;

  // flow predictor state
  int unsigned src_reg = 0, snk_reg = 1;
  int unsigned e_to[SLOTS], e_res[SLOTS], e_link[SLOTS];
  int e_gain[SLOTS];
  int unsigned head[NODES], n_pred[NODES], n_bott[NODES], n_hops[NODES], wq[NODES];
  longint n_dist[NODES];
  bit n_queued[NODES], n_reached[NODES];
  int unsigned e_count = 1;
  longint gain_total = 0;

  function automatic void clear_graph();
    for (int n = 0; n < NODES; n++) begin
      head[n] = 0;
      n_queued[n] = 0;
    end
    e_count = 1;
    gain_total = 0;
  endfunction

  function automatic void link_edge(int unsigned a, int unsigned b, int unsigned c, int g);
    e_count++;
    e_to[e_count] = b;
    e_res[e_count] = c;
    e_gain[e_count] = g;
    e_link[e_count] = head[a];
    head[a] = e_count;
  endfunction

  function automatic int path_search(int unsigned s, int unsigned d);
    int unsigned qh, qn, u, i, v;
    longint cand;
    qh = 0;
    for (int n = 0; n < NODES; n++) begin
      n_reached[n] = 0;
      n_queued[n] = 0;
      n_bott[n] = 0;
    end
    n_reached[s] = 1;
    n_dist[s] = 0;
    n_bott[s] = LIMIT;
    n_hops[s] = 0;
    n_queued[s] = 1;
    wq[0] = s;
    qn = 1;
    while (qn > 0) begin
      u = wq[qh];
      qh = (qh + 1) % NODES;
      qn--;
      n_queued[u] = 0;
      for (i = head[u]; i != 0 && i < SLOTS; i = e_link[i]) begin
        v = e_to[i];
        if (e_res[i] == 0) continue;
        cand = n_dist[u] + longint'(e_gain[i]);
        if (n_reached[v] && cand <= n_dist[v]) continue;
        if (n_hops[u] + 1 >= NODES) return 2;
        n_reached[v] = 1;
        n_dist[v] = cand;
        n_pred[v] = i;
        n_hops[v] = n_hops[u] + 1;
        n_bott[v] = (n_bott[u] < e_res[i]) ? n_bott[u] : e_res[i];
        if (!n_queued[v] && qn < NODES) begin
          n_queued[v] = 1;
          wq[(qh + qn) % NODES] = v;
          qn++;
        end
      end
    end
    return (n_reached[d] && n_bott[d] > 0) ? 1 : 0;
  endfunction

  function automatic longint max_gain_flow();
    int unsigned f, v, steps, i, j, r;
    if (src_reg == snk_reg) return 0;
    while (path_search(src_reg, snk_reg) == 1) begin
      f = n_bott[snk_reg];
      v = snk_reg;
      steps = 0;
      while (v != src_reg && steps < NODES) begin
        i = n_pred[v];
        j = i ^ 1;
        e_res[i] -= f;
        r = e_res[j];
        e_res[j] = (mcf_pkg::CAP_MAX - r < f) ? mcf_pkg::CAP_MAX : r + f;
        v = e_to[j];
        steps++;
      end
      gain_total += longint'(f) * n_dist[snk_reg];
    end
    return gain_total;
  endfunction

  function automatic void take_edge(step_t e);
    if (e_count + 2 <= SLOTS - 1) begin
      link_edge(32'(e.from_n), 32'(e.to_n), 32'(e.cap), int'(e.cost));
      link_edge(32'(e.to_n), 32'(e.from_n), 0, -int'(e.cost));
    end
    if (e.last) begin
      expected_totals = {expected_totals, max_gain_flow()};
      clear_graph();
    end
  endfunction

  function automatic void put_step(step_t s);
    pending = {pending, s};
  endfunction

  function automatic void add_edge(int a, int b, int unsigned c, int g, bit l);
    step_t s;
    s.kind = K_EDGE;
    s.from_n = mcf_pkg::NODE_W'(a);
    s.to_n = mcf_pkg::NODE_W'(b);
    s.cap = mcf_pkg::CAP_W'(c);
    s.cost = mcf_pkg::COST_W'(g);
    s.last = l;
    s.idx = '0;
    s.data = '0;
    put_step(s);
  endfunction

  function automatic void add_cfg(int unsigned s_node, int unsigned d_node);
    step_t s;
    s = '{kind: K_CFG, default: '0};
    s.idx = mcf_pkg::CFG_SOURCE;
    s.data = mcf_pkg::CFG_DATA_W'(s_node);
    put_step(s);
    s.idx = mcf_pkg::CFG_SINK;
    s.data = mcf_pkg::CFG_DATA_W'(d_node);
    put_step(s);
  endfunction

  function automatic void add_drain();
    step_t s;
    s = '{kind: K_DRAIN, default: '0};
    put_step(s);
  endfunction

  function automatic int unsigned rand_cap();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom() & mcf_pkg::CAP_MAX;
      2: return mcf_pkg::CAP_MAX;
      default: return $urandom_range(50, 1);
    endcase
  endfunction

  function automatic int rand_cost();
    case ($urandom_range(9))
      0: return int'($urandom_range(2097151)) - 1048576;
      1: return -1048576;
      2: return 1048575;
      default: return int'($urandom_range(40)) - 20;
    endcase
  endfunction

  function automatic int src_reg_plan(int s_node, int k);
    return (k < 15) ? 0 : s_node;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    int pool[12];
    int npool, nedges, s_node, d_node;
    add_cfg(0, 1);
    add_edge(0, 1, mcf_pkg::CAP_MAX, 1048575, 1);
    add_edge(0, 2, 5, -1048576, 0);
    add_edge(2, 1, 7, 3, 1);
    add_edge(0, 1, 0, 9, 1);
    // positive-gain cycle on the way to the sink
    add_edge(0, 2, 10, 1, 0);
    add_edge(2, 3, 10, 5, 0);
    add_edge(3, 2, 10, 5, 0);
    add_edge(3, 1, 10, 0, 1);
    add_cfg(3, 3);
    add_edge(3, 4, 8, 2, 0);
    add_edge(4, 3, 8, 2, 1);
    add_cfg(511, 0);
    add_edge(511, 0, 1, -1, 0);
    add_edge(511, 0, 300, 7, 0);
    add_edge(511, 170, 40, -1048576, 0);
    add_edge(170, 0, 35, 1048575, 1);
    add_drain();
    add_cfg(0, 1);
    for (int k = 0; k < 188; k++) begin
      if (k % 15 == 0) begin
        s_node = $urandom_range(511);
        d_node = ($urandom_range(9) == 0) ? s_node : $urandom_range(511);
        add_cfg(s_node, d_node);
      end
      npool = $urandom_range(12, 3);
      pool[0] = src_reg_plan(s_node, k);
      pool[1] = d_node;
      for (int p = 2; p < npool; p++) pool[p] = $urandom_range(511);
      nedges = ($urandom_range(9) == 0) ? $urandom_range(30, 1) : $urandom_range(12, 1);
      for (int e = 0; e < nedges; e++)
        add_edge(pool[$urandom_range(npool - 1)], pool[$urandom_range(npool - 1)],
                 rand_cap(), rand_cost(), e == nedges - 1);
      if (k % 40 == 20) add_drain();
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      cycles++;
      if (cfg_we) begin
        if (cfg_index == mcf_pkg::CFG_SOURCE) src_reg = 32'(cfg_wdata);
        else src_reg = src_reg;
        if (cfg_index == mcf_pkg::CFG_SINK) snk_reg = 32'(cfg_wdata);
      end
      if (in_valid && !in_stall) begin
        step_t e;
        e.kind = K_EDGE;
        e.from_n = in_from_node;
        e.to_n = in_to_node;
        e.cap = in_capacity;
        e.cost = in_cost;
        e.last = in_last_edge;
        in_took = 1;
        accepted++;
        take_edge(e);
      end
      if (out_valid && !out_stall) begin
        if (expected_totals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected total %0d", out_total_cost);
        end else begin
          if (out_total_cost !== expected_totals[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("total mismatch: expected %0d actual %0d",
                       expected_totals[0], out_total_cost);
          end
          void'(expected_totals.pop_front());
        end
      end
    end
  end

  always @(negedge clk) begin
    bit nv, nwe, calm;
    step_t s;
    calm = (accepted >= 300 && accepted < 700);
    nv = in_valid && !in_took;
    nwe = 0;
    if (rst_n) begin
      out_stall <= (cycles % 20000 < 4000) ? 1'b0 : ($urandom_range(99) < 21);
      if (!nv) begin
        in_took = 0;
        if (pending.size() > 0) begin
          s = pending[0];
          if (s.kind == K_EDGE) begin
            settle = 0;
            if (calm || $urandom_range(99) >= 21) begin
              nv = 1;
              in_from_node <= s.from_n;
              in_to_node <= s.to_n;
              in_capacity <= s.cap;
              in_cost <= s.cost;
              in_last_edge <= s.last;
              void'(pending.pop_front());
            end
          end else if (expected_totals.size() == 0) begin
            settle++;
            if (settle >= 16) begin
              settle = 0;
              if (s.kind == K_CFG) begin
                nwe = 1;
                cfg_index <= s.idx;
                cfg_wdata <= s.data;
              end
              void'(pending.pop_front());
            end
          end else settle = 0;
        end
      end
      in_valid <= nv;
      cfg_we <= nwe;
    end
  end

  initial begin
    wait (rst_n);
    wait (pending.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (expected_totals.size() == 0);
    repeat (1200) @(posedge clk);
    if (mismatches == 0 && expected_totals.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
